/* src/lcbc_pkg.sv */
// shared types and constants for the luhn card brand check
package lcbc_pkg;

   localparam int CardWidth     = 54;
   localparam int NumDigits     = 17;
   localparam int BcdWidth      = NumDigits * 4;
   localparam int BitCntWidth   = $clog2(CardWidth);
   localparam int DigitIdxWidth = $clog2(NumDigits);

   typedef logic [3:0] digit_type;
   typedef logic [4:0] count_type;
   typedef logic [1:0] brand_type;

   localparam brand_type BRAND_INVALID    = 2'd0;
   localparam brand_type BRAND_AMEX       = 2'd1;
   localparam brand_type BRAND_MASTERCARD = 2'd2;
   localparam brand_type BRAND_VISA       = 2'd3;

   localparam count_type LEN_AMEX   = 5'd15;
   localparam count_type LEN_SIXTEEN = 5'd16;
   localparam count_type LEN_THIRTEEN = 5'd13;

   typedef struct packed {
      logic load;
      logic shift_bit;
      logic shift_digit;
   } conv_ctrl_type;

   typedef struct packed {
      logic      clear;
      logic      step;
      count_type index;
   } scan_ctrl_type;

   typedef struct packed {
      digit_type remainder;
      count_type count;
      digit_type top;
      digit_type second;
   } scan_status_type;

endpackage

/* src/lcbc_bcd_conv.sv */
// bit-serial binary to decimal converter with digit shift-out
module lcbc_bcd_conv (
   input  logic                            clock,
   input  lcbc_pkg::conv_ctrl_type         ctrl,
   input  logic [lcbc_pkg::CardWidth-1:0]  card_value,
   output lcbc_pkg::digit_type             low_digit
);
   import lcbc_pkg::*;

   logic [CardWidth-1:0] bin_ff, bin_in;
   logic [BcdWidth-1:0]  bcd_ff, bcd_in;
   logic [BcdWidth-1:0]  adj;

   always_comb begin
      for (int i = 0; i < NumDigits; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                    : bcd_ff[i*4 +: 4];
      end
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         bin_in = card_value;
         bcd_in = '0;
      end else if (ctrl.shift_bit) begin
         bin_in = {bin_ff[CardWidth-2:0], 1'b0};
         bcd_in = {adj[BcdWidth-2:0], bin_ff[CardWidth-1]};
      end else if (ctrl.shift_digit) begin
         bcd_in = {4'd0, bcd_ff[BcdWidth-1:4]};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign low_digit = bcd_ff[3:0];

endmodule

/* src/lcbc_digit_sum.sv */
// serial luhn digit accumulator with length and prefix capture
module lcbc_digit_sum (
   input  logic                      clock,
   input  lcbc_pkg::scan_ctrl_type   ctrl,
   input  lcbc_pkg::digit_type       digit,
   output lcbc_pkg::scan_status_type status
);
   import lcbc_pkg::*;

   digit_type sum_ff, sum_in;
   count_type count_ff, count_in;
   digit_type top_ff, top_in;
   digit_type second_ff, second_in;
   digit_type prev_ff, prev_in;
   logic [4:0] dbl;
   digit_type  term;
   logic [4:0] total;

   always_comb begin
      dbl = {digit, 1'b0};
      if (ctrl.index[0]) begin
         term = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
      end else begin
         term = digit;
      end
      total = {1'b0, sum_ff} + {1'b0, term};

      sum_in    = sum_ff;
      count_in  = count_ff;
      top_in    = top_ff;
      second_in = second_ff;
      prev_in   = prev_ff;
      if (ctrl.clear) begin
         sum_in    = '0;
         count_in  = '0;
         top_in    = '0;
         second_in = '0;
         prev_in   = '0;
      end else if (ctrl.step) begin
         sum_in  = (total >= 5'd10) ? 4'(total - 5'd10) : total[3:0];
         prev_in = digit;
         if (digit != 4'd0) begin
            count_in  = ctrl.index + 5'd1;
            top_in    = digit;
            second_in = prev_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      count_ff  <= count_in;
      top_ff    <= top_in;
      second_ff <= second_in;
      prev_ff   <= prev_in;
   end

   assign status.remainder = sum_ff;
   assign status.count     = count_ff;
   assign status.top       = top_ff;
   assign status.second    = second_ff;

endmodule

/* src/luhn_card_brand_check.sv */
// Luhn mod-10 card check with brand decode. A card number passes from its
// transfer through the bit-serial shift-add-3 decimal converter (one input
// bit per cycle), then the digit accumulator (one decimal digit per cycle),
// and then the brand decode into the output register. A new card is taken
// only after the last one has written its result to the output register.
// The input stalls from the transfer until that write, and longer while a
// previous result still sits unaccepted in the output register; a result
// that has reached the output register waits there, and a new card number
// is taken while it waits.
module luhn_card_brand_check #(
   parameter int MAX_DIGITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lcbc_pkg::CardWidth-1:0]  req_card_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [3:0]                      rsp_luhn_remainder,
   output logic [1:0]                      rsp_brand,
   output logic [4:0]                      rsp_digit_count
);
   import lcbc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic [BitCntWidth-1:0] LastBit   = BitCntWidth'(CardWidth - 1);
   localparam logic [BitCntWidth-1:0] LastDigit = BitCntWidth'(NumDigits - 1);
   localparam count_type MaxCount = count_type'(MAX_DIGITS);

   logic [1:0]             state_ff, state_in;
   logic [BitCntWidth-1:0] cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   digit_type              rem_ff, rem_in;
   brand_type              brand_ff, brand_in;
   count_type              count_ff, count_in;

   conv_ctrl_type   conv_ctrl;
   scan_ctrl_type   scan_ctrl;
   scan_status_type status;
   digit_type       low_digit;
   brand_type       brand;
   logic            accept;
   logic            out_free;

   lcbc_bcd_conv u_conv (
      .clock      (clock),
      .ctrl       (conv_ctrl),
      .card_value (req_card_value),
      .low_digit  (low_digit)
   );

   lcbc_digit_sum u_sum (
      .clock  (clock),
      .ctrl   (scan_ctrl),
      .digit  (low_digit),
      .status (status)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // brand decode on the final accumulator state
   always_comb begin
      brand = BRAND_INVALID;
      if (status.remainder == 4'd0 && status.count <= MaxCount) begin
         case (status.count)
            LEN_AMEX: begin
               if (status.top == 4'd3 && (status.second == 4'd4 || status.second == 4'd7))
                  brand = BRAND_AMEX;
            end
            LEN_SIXTEEN: begin
               if (status.top == 4'd5 && status.second >= 4'd1 && status.second <= 4'd5)
                  brand = BRAND_MASTERCARD;
               else if (status.top == 4'd4)
                  brand = BRAND_VISA;
            end
            LEN_THIRTEEN: begin
               if (status.top == 4'd4)
                  brand = BRAND_VISA;
            end
            default: brand = BRAND_INVALID;
         endcase
      end
   end

   always_comb begin
      state_in              = state_ff;
      cnt_in                = cnt_ff;
      rsp_valid_in          = rsp_valid_ff && rsp_stall;
      rem_in                = rem_ff;
      brand_in              = brand_ff;
      count_in              = count_ff;
      conv_ctrl             = '0;
      scan_ctrl             = '0;
      scan_ctrl.index       = cnt_ff[DigitIdxWidth-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               conv_ctrl.load = 1'b1;
               cnt_in         = '0;
               state_in       = ST_CONV;
            end
         end
         ST_CONV: begin
            conv_ctrl.shift_bit = 1'b1;
            if (cnt_ff == LastBit) begin
               cnt_in          = '0;
               scan_ctrl.clear = 1'b1;
               state_in        = ST_SCAN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            conv_ctrl.shift_digit = 1'b1;
            scan_ctrl.step        = 1'b1;
            if (cnt_ff == LastDigit) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rem_in       = status.remainder;
               brand_in     = brand;
               count_in     = status.count;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      brand_ff <= brand_in;
      count_ff <= count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_luhn_remainder = rem_ff;
   assign rsp_brand          = brand_ff;
   assign rsp_digit_count    = count_ff;

   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CONV)
      else $error("transfer did not start conversion");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result appeared outside the done state");

   a_brand_needs_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_brand == BRAND_INVALID || rsp_luhn_remainder == 4'd0))
      else $error("brand given for a failing checksum");

   a_remainder_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_luhn_remainder <= 4'd9)
      else $error("remainder out of range");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> cnt_ff <= LastDigit)
      else $error("digit index past the last digit");

endmodule
